FILE: src/max_frequency_stack_top_macros.svh
// Assertion macros for the maximum-frequency stack checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MAX_FREQUENCY_STACK_TOP_MACROS_SVH
`define MAX_FREQUENCY_STACK_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mfs_pkg.sv
// Shared types and codes for the maximum-frequency stack.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package mfs_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_PUSH_OK    = 2'd0;
  localparam status_t ST_POP_OK     = 2'd1;
  localparam status_t ST_POP_EMPTY  = 2'd2;
  localparam status_t ST_PUSH_FULL  = 2'd3;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

endpackage

FILE: src/mfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/max_frequency_stack_top.sv
// Top level of the maximum-frequency stack.
// Depends on mfs_pkg and mfs_ram.
`timescale 1ns / 1ps

// Usage
//   Command port: a word (in_func, in_value_in) is taken at a rising edge
//   where start is high and busy is low. in_func selects push of
//   in_value_in or pop of the most frequent, most recently pushed value.
//   Result port: out_valid is high for exactly one cycle with out_value_out
//   and out_status. The receiver cannot stall; every result must be taken
//   in the cycle it is shown.
// Timing
//   A successful push or pop passes through the look and update states and
//   shows its result in the same cycle as busy falls; no new word is taken
//   before then. The chain of dependent registered memory reads
//   (count or level head, then entry store) is why it spans these states.
//   A pop on an empty stack or a push on a full one shows its result in
//   the next cycle and the block stays ready.
// Reset
//   After rst_n is released, a clearing pass zeroes the count table and
//   fills the free-slot stack; busy stays high throughout.

module max_frequency_stack_top #(
  parameter int VALUE_BITS = 8,
  parameter int CAPACITY   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [VALUE_BITS-1:0] in_value_in,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_value_out,
  output mfs_pkg::status_t      out_status
);

  import mfs_pkg::*;

  localparam int NUM_VALUES = 1 << VALUE_BITS;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int PTR_W      = $clog2(CAPACITY + 1);
  localparam int ENT_W      = VALUE_BITS + PTR_W;
  localparam int CLR_N      = (NUM_VALUES > CAPACITY) ? NUM_VALUES : CAPACITY;
  localparam int CLR_W      = $clog2(CLR_N);

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t                state_r;
  logic [CLR_W-1:0]      clr_r;
  logic                  func_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [PTR_W-1:0]      lvl_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [PTR_W-1:0]      top_r;
  logic [PTR_W-1:0]      free_top_r;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  status_t               out_status_r;

  // Memory ports.
  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [PTR_W-1:0]      cnt_wdata;
  logic [PTR_W-1:0]      cnt_rdata;
  logic                  head_we;
  logic [SLOT_W-1:0]     head_waddr;
  logic [PTR_W-1:0]      head_wdata;
  logic [SLOT_W-1:0]     head_raddr;
  logic [PTR_W-1:0]      head_rdata;
  logic                  ent_we;
  logic [SLOT_W-1:0]     ent_waddr;
  logic [ENT_W-1:0]      ent_wdata;
  logic [ENT_W-1:0]      ent_rdata;
  logic                  free_we;
  logic [SLOT_W-1:0]     free_waddr;
  logic [SLOT_W-1:0]     free_wdata;
  logic [SLOT_W-1:0]     free_rdata;

  logic                  is_full;
  logic                  is_empty;
  logic [PTR_W-1:0]      top_m1;
  logic [PTR_W-1:0]      free_top_m1;
  logic [PTR_W-1:0]      lvl_nxt;
  logic [PTR_W-1:0]      lvl_nxt_m1;
  logic [PTR_W-1:0]      lvl_r_m1;
  logic [PTR_W-1:0]      push_next;
  logic [VALUE_BITS-1:0] ent_value;
  logic [PTR_W-1:0]      ent_next;
  logic                  clr_in_values;
  logic                  clr_in_slots;

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  assign is_full     = (free_top_r == '0);
  assign is_empty    = (top_r == '0);
  assign top_m1      = top_r - PTR_W'(1);
  assign free_top_m1 = free_top_r - PTR_W'(1);
  assign lvl_nxt     = (cnt_rdata >= NIL_PTR) ? NIL_PTR : cnt_rdata + PTR_W'(1);
  assign lvl_nxt_m1  = lvl_nxt - PTR_W'(1);
  assign lvl_r_m1    = lvl_r - PTR_W'(1);
  assign push_next   = (lvl_r > top_r) ? NIL_PTR : head_rdata;
  assign ent_value   = ent_rdata[ENT_W-1:PTR_W];
  assign ent_next    = ent_rdata[PTR_W-1:0];

  assign clr_in_values = ({1'b0, clr_r} < (CLR_W + 1)'(NUM_VALUES));
  assign clr_in_slots  = ({1'b0, clr_r} < (CLR_W + 1)'(CAPACITY));

  // Reads are issued in the accept cycle from the command word and the
  // level/free-stack registers, and in the look cycle from returned data.
  logic [VALUE_BITS-1:0] cnt_raddr;
  logic [SLOT_W-1:0]     free_raddr;
  logic [SLOT_W-1:0]     ent_raddr;

  assign cnt_raddr  = in_value_in;
  assign free_raddr = free_top_m1[SLOT_W-1:0];
  assign head_raddr = (state_r == S_LOOK) ? lvl_nxt_m1[SLOT_W-1:0] : top_m1[SLOT_W-1:0];
  assign ent_raddr  = head_rdata[SLOT_W-1:0];

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = '0;
    cnt_wdata  = '0;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = '0;
    free_we    = 1'b0;
    free_waddr = '0;
    free_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        cnt_we     = clr_in_values;
        cnt_waddr  = clr_r[VALUE_BITS-1:0];
        free_we    = clr_in_slots;
        free_waddr = clr_r[SLOT_W-1:0];
        free_wdata = clr_r[SLOT_W-1:0];
      end
      S_LOOK: begin
        if (func_r == FUNC_PUSH) begin
          cnt_we    = 1'b1;
          cnt_waddr = val_r;
          cnt_wdata = lvl_nxt;
        end
      end
      S_UPD: begin
        if (func_r == FUNC_PUSH) begin
          ent_we     = 1'b1;
          ent_waddr  = slot_r;
          ent_wdata  = {val_r, push_next};
          head_we    = 1'b1;
          head_waddr = lvl_r_m1[SLOT_W-1:0];
          head_wdata = PTR_W'(slot_r);
        end else begin
          head_we    = 1'b1;
          head_waddr = top_m1[SLOT_W-1:0];
          head_wdata = ent_next;
          free_we    = 1'b1;
          free_waddr = free_top_r[SLOT_W-1:0];
          free_wdata = slot_r;
          // The entry on top of the highest level always belongs to a value
          // whose count equals that level, so its new count is level - 1.
          cnt_we     = 1'b1;
          cnt_waddr  = ent_value;
          cnt_wdata  = top_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      top_r       <= '0;
      free_top_r  <= NIL_PTR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_r == CLR_W'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_r <= in_func;
            val_r  <= in_value_in;
            if (in_func == FUNC_PUSH && is_full) begin
              out_valid_r  <= 1'b1;
              out_value_r  <= '0;
              out_status_r <= ST_PUSH_FULL;
            end else if (in_func == FUNC_POP && is_empty) begin
              out_valid_r  <= 1'b1;
              out_value_r  <= '0;
              out_status_r <= ST_POP_EMPTY;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          lvl_r   <= lvl_nxt;
          slot_r  <= (func_r == FUNC_PUSH) ? free_rdata : head_rdata[SLOT_W-1:0];
          state_r <= S_UPD;
        end
        S_UPD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          if (func_r == FUNC_PUSH) begin
            out_value_r  <= '0;
            out_status_r <= ST_PUSH_OK;
            free_top_r   <= free_top_m1;
            if (lvl_r > top_r) begin
              top_r <= lvl_r;
            end
          end else begin
            out_value_r  <= ent_value;
            out_status_r <= ST_POP_OK;
            free_top_r   <= free_top_r + PTR_W'(1);
            if (ent_next >= NIL_PTR) begin
              top_r <= top_m1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  mfs_ram #(.WIDTH(PTR_W), .DEPTH(NUM_VALUES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mfs_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  mfs_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  mfs_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

endmodule

FILE: src/mfs_check.sv
// Port-level checker for the maximum-frequency stack, bound to the top level.
// Depends on mfs_pkg and max_frequency_stack_top_macros.svh.
`timescale 1ns / 1ps
`include "max_frequency_stack_top_macros.svh"

module mfs_check #(
  parameter int VALUE_BITS = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_func,
  input logic                  out_valid,
  input logic [VALUE_BITS-1:0] out_value_out,
  input mfs_pkg::status_t      out_status
);

  import mfs_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // Only a successful pop carries a value word.
  `MFS_ASSERT_NOW(a_value_zero, out_valid && out_status != ST_POP_OK, out_value_out == '0, "nonzero value on a result other than a pop")

  // A taken word either fails at once or keeps the block busy.
  `MFS_ASSERT_NEXT(a_accept_busy, accept, out_valid || busy, "accepted word neither answered nor in progress")

  // Successful operations answer once the word has passed the look and update states.
  `MFS_ASSERT_NOW(a_ok_latency, out_valid && (out_status == ST_PUSH_OK || out_status == ST_POP_OK), $past(accept, 3), "successful result without a word accepted three cycles earlier")

  // A pop on an empty stack answers in the next cycle.
  `MFS_ASSERT_NOW(a_empty_latency, out_valid && out_status == ST_POP_EMPTY, $past(accept && in_func == FUNC_POP, 1), "empty-pop result without a pop accepted the cycle before")

endmodule

bind max_frequency_stack_top mfs_check #(.VALUE_BITS(VALUE_BITS)) u_mfs_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_value_out (out_value_out),
  .out_status    (out_status)
);
